@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ src/m3acc_pkg.sv @@
// package for the 3x3 accumulator unit: types, codes, constants, saturation helper
package m3acc_pkg;

    localparam int DATA_W        = 32;
    localparam int DIM           = 3;
    localparam int ELEMS         = 9;
    localparam int IDX_W         = 4;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_EMUL  = 4'd3,
        OP_ACCB  = 4'd4,
        OP_BACC  = 4'd5,
        OP_SCALE = 4'd6,
        OP_DIV   = 4'd7,
        OP_TRANS = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MAC,
        ST_DIV,
        ST_WR,
        ST_OUT
    } state_t;

    // control from sequencer to divider
    typedef struct packed {
        logic  start;
        elem_t dividend;
        elem_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        logic  busy;
        elem_t quot;
        logic  ovf;
    } div_rsp_t;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // saturate a wide signed value to 32 bits
    function automatic elem_t sat32(input logic signed [67:0] v, output logic ovf);
        ovf = 1'b0;
        if (v > 68'sd2147483647) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < -68'sd2147483648) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

@@ src/m3acc_div.sv @@
// restoring divider: (a << frac) / b, truncated toward zero, saturated
module m3acc_div #(
    parameter int FRAC_BITS = m3acc_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  m3acc_pkg::div_req_t  req,
    output m3acc_pkg::div_rsp_t  rsp
);
    import m3acc_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DATA_W:0]  rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DATA_W:0]  rem_shift;
    logic [DATA_W:0]  rem_sub;
    logic [NUM_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic signed [NUM_W+1:0] q_signed;
    logic             q_ovf;
    elem_t            q_sat;

    assign a_mag = req.dividend[DATA_W-1]
        ? NUM_W'(-{{FRAC_BITS{req.dividend[DATA_W-1]}}, req.dividend}) << FRAC_BITS
        : NUM_W'({{FRAC_BITS{1'b0}}, req.dividend}) << FRAC_BITS;
    assign b_mag = req.divisor[DATA_W-1] ? DATA_W'(-req.divisor) : req.divisor;

    assign rem_shift = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                num_reg  <= a_mag;
                den_reg  <= b_mag;
                rem_reg  <= '0;
                neg_reg  <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!rem_sub[DATA_W]) begin
                    rem_reg <= rem_sub;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // num_reg holds the unsigned quotient once done
    assign q_signed = neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg});

    always_comb begin
        q_sat = sat32(68'(q_signed), q_ovf);
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = q_sat;
    assign rsp.ovf  = q_ovf;

endmodule

@@ src/matrix3x3_accumulator_unit.sv @@
// top level: 3x3 q-format accumulator with sequenced read-modify-write over a memory
//
// elements are processed one at a time by the single shared mac and the bit-serial
// divider; one item in flight, next input beat taken the cycle after the result beat
// is accepted
// reset: synchronous active-low aresetn; the accumulator memory is cleared by
// a sweep over all nine elements after reset before the first input beat is taken
`include "assert_macros.svh"

module matrix3x3_accumulator_unit #(
    parameter int FRAC_BITS = m3acc_pkg::FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [3:0]              s_mode,
    input  m3acc_pkg::elem_t        s_scalar,
    input  m3acc_pkg::elem_t        s_opnd_r0c0,
    input  m3acc_pkg::elem_t        s_opnd_r0c1,
    input  m3acc_pkg::elem_t        s_opnd_r0c2,
    input  m3acc_pkg::elem_t        s_opnd_r1c0,
    input  m3acc_pkg::elem_t        s_opnd_r1c1,
    input  m3acc_pkg::elem_t        s_opnd_r1c2,
    input  m3acc_pkg::elem_t        s_opnd_r2c0,
    input  m3acc_pkg::elem_t        s_opnd_r2c1,
    input  m3acc_pkg::elem_t        s_opnd_r2c2,
    output logic                    m_valid,
    input  logic                    m_ready,
    output m3acc_pkg::elem_t        m_res_r0c0,
    output m3acc_pkg::elem_t        m_res_r0c1,
    output m3acc_pkg::elem_t        m_res_r0c2,
    output m3acc_pkg::elem_t        m_res_r1c0,
    output m3acc_pkg::elem_t        m_res_r1c1,
    output m3acc_pkg::elem_t        m_res_r1c2,
    output m3acc_pkg::elem_t        m_res_r2c0,
    output m3acc_pkg::elem_t        m_res_r2c1,
    output m3acc_pkg::elem_t        m_res_r2c2,
    output logic                    m_overflow,
    output logic                    m_div_zero
);
    import m3acc_pkg::*;

    // accumulator memory, one read port, one write port, registered read
    elem_t acc_mem [ELEMS];
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    elem_t            wr_data;
    elem_t            rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) acc_mem[wr_addr] <= wr_data;
        rd_data_reg <= acc_mem[rd_addr];
    end

    // captured beat
    logic [3:0] mode_reg;
    elem_t      scalar_reg;
    elem_t      b_reg [ELEMS];
    // snapshot of the old accumulator, read out of memory first
    elem_t      a_reg [ELEMS];
    // new values, written back at the end
    elem_t      r_reg [ELEMS];
    logic       ovf_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;   // element index
    logic [1:0]       k_reg, k_next;       // mac term
    logic             clr_reg;             // post-reset clearing sweep
    logic             m_valid_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic signed [67:0] sum_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    m3acc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dreq),
        .rsp    (drsp)
    );

    elem_t s_opnd [ELEMS];
    assign s_opnd[0] = s_opnd_r0c0;
    assign s_opnd[1] = s_opnd_r0c1;
    assign s_opnd[2] = s_opnd_r0c2;
    assign s_opnd[3] = s_opnd_r1c0;
    assign s_opnd[4] = s_opnd_r1c1;
    assign s_opnd[5] = s_opnd_r1c2;
    assign s_opnd[6] = s_opnd_r2c0;
    assign s_opnd[7] = s_opnd_r2c1;
    assign s_opnd[8] = s_opnd_r2c2;

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE) && !clr_reg && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;

    // row and column of the current element
    logic [1:0] row, col;
    assign row = (idx_reg >= IDX_W'(6)) ? 2'd2 : (idx_reg >= IDX_W'(3)) ? 2'd1 : 2'd0;
    assign col = 2'(idx_reg - IDX_W'(row) * IDX_W'(DIM));

    // single shared multiplier, operands picked by mode
    elem_t mul_a, mul_b;
    always_comb begin
        mul_a = a_reg[idx_reg];
        mul_b = b_reg[idx_reg];
        unique case (mode_reg)
            OP_ACCB: begin
                mul_a = a_reg[IDX_W'(row) * IDX_W'(DIM) + IDX_W'(k_reg)];
                mul_b = b_reg[IDX_W'(k_reg) * IDX_W'(DIM) + IDX_W'(col)];
            end
            OP_BACC: begin
                mul_a = b_reg[IDX_W'(row) * IDX_W'(DIM) + IDX_W'(k_reg)];
                mul_b = a_reg[IDX_W'(k_reg) * IDX_W'(DIM) + IDX_W'(col)];
            end
            OP_SCALE: mul_b = scalar_reg;
            default: ;
        endcase
    end

    logic signed [63:0] prod;
    logic signed [63:0] prod_q;
    assign prod   = mul_a * mul_b;
    assign prod_q = prod >>> FRAC_BITS;   // arithmetic shift is floor

    // one-element result for the simple modes
    logic signed [67:0] simple_wide;
    elem_t              simple_val;
    logic               simple_ovf;
    logic               sat_ovf;
    elem_t              sum_sat;
    logic               sum_ovf;
    always_comb begin
        simple_wide = 68'(a_reg[idx_reg]);
        unique case (mode_reg)
            OP_LOAD:  simple_wide = 68'(b_reg[idx_reg]);
            OP_ADD:   simple_wide = 68'(a_reg[idx_reg]) + 68'(b_reg[idx_reg]);
            OP_SUB:   simple_wide = 68'(a_reg[idx_reg]) - 68'(b_reg[idx_reg]);
            OP_EMUL, OP_SCALE: simple_wide = 68'(prod_q);
            OP_TRANS: simple_wide = 68'(a_reg[IDX_W'(col) * IDX_W'(DIM) + IDX_W'(row)]);
            default: ;
        endcase
        simple_val = sat32(simple_wide, sat_ovf);
        simple_ovf = sat_ovf;
        sum_sat    = sat32(sum_reg + 68'(prod_q), sum_ovf);
    end

    // sequencer
    logic ld_a, st_simple, st_mac, st_div_res, div_start, clr_sum;
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = r_reg[idx_reg];
        ld_a       = 1'b0;
        st_simple  = 1'b0;
        st_mac     = 1'b0;
        st_div_res = 1'b0;
        div_start  = 1'b0;
        clr_sum    = 1'b0;
        if (clr_reg) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (clr_reg) begin
                    idx_next = (idx_reg == IDX_W'(ELEMS - 1)) ? '0 : idx_reg + 1'b1;
                end else if (s_fire) begin
                    state_next = ST_RD;
                    idx_next   = '0;
                end
            end
            ST_RD: begin
                // issue reads 0..8, read data lands in the following cycle
                ld_a = rd_pend_reg;
                if (idx_reg != IDX_W'(ELEMS)) idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(ELEMS) && !rd_pend_reg) begin
                    idx_next = '0;
                    k_next   = '0;
                    clr_sum  = 1'b1;
                    if (mode_reg == OP_ACCB || mode_reg == OP_BACC) begin
                        state_next = ST_MAC;
                    end else if (mode_reg == OP_DIV && scalar_reg != '0) begin
                        state_next = ST_DIV;
                        div_start  = 1'b1;
                    end else begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (mode_reg == OP_ACCB || mode_reg == OP_BACC) begin
                    if (k_reg == 2'd2) begin
                        st_mac  = 1'b1;
                        k_next  = '0;
                        clr_sum = 1'b1;
                        if (idx_reg == IDX_W'(ELEMS - 1)) begin
                            state_next = ST_WR;
                            idx_next   = '0;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    st_simple = 1'b1;
                    if (idx_reg == IDX_W'(ELEMS - 1)) begin
                        state_next = ST_WR;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (drsp.done) begin
                    st_div_res = 1'b1;
                    if (idx_reg == IDX_W'(ELEMS - 1)) begin
                        state_next = ST_WR;
                        idx_next   = '0;
                    end else begin
                        idx_next  = idx_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_WR: begin
                wr_en = 1'b1;
                if (idx_reg == IDX_W'(ELEMS - 1)) begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divider operand follows the element about to be divided
    logic [IDX_W-1:0] div_idx;
    assign div_idx = (state_reg == ST_DIV) ? idx_reg + 1'b1 : '0;
    assign dreq.start    = div_start;
    assign dreq.dividend = a_reg[div_idx];
    assign dreq.divisor  = scalar_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            k_reg       <= '0;
            clr_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            if (clr_reg && idx_reg == IDX_W'(ELEMS - 1)) clr_reg <= 1'b0;
            rd_pend_reg <= (state_reg == ST_RD) && (idx_reg != IDX_W'(ELEMS));
            if (state_reg == ST_OUT)         m_valid_reg <= 1'b1;
            else if (m_valid && m_ready)     m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= idx_reg;
        if (s_fire) begin
            mode_reg   <= s_mode;
            scalar_reg <= s_scalar;
            for (int i = 0; i < ELEMS; i++) b_reg[i] <= s_opnd[i];
            ovf_reg    <= 1'b0;
        end
        if (ld_a) a_reg[rd_idx_reg] <= rd_data_reg;
        if (clr_sum) sum_reg <= '0;
        else if (state_reg == ST_MAC) sum_reg <= sum_reg + 68'(prod_q);
        if (st_simple) begin
            if (mode_reg == OP_DIV) begin
                // zero divisor: sign saturation
                r_reg[idx_reg] <= (a_reg[idx_reg] == '0) ? '0
                                : a_reg[idx_reg][DATA_W-1] ? Q_MIN : Q_MAX;
            end else if (mode_reg > OP_TRANS) begin
                r_reg[idx_reg] <= a_reg[idx_reg];
            end else begin
                r_reg[idx_reg] <= simple_val;
                if (mode_reg != OP_LOAD && mode_reg != OP_TRANS)
                    ovf_reg <= ovf_reg | simple_ovf;
            end
        end
        if (st_mac) begin
            r_reg[idx_reg] <= sum_sat;
            ovf_reg        <= ovf_reg | sum_ovf;
        end
        if (st_div_res) begin
            r_reg[idx_reg] <= drsp.quot;
            ovf_reg        <= ovf_reg | drsp.ovf;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_res_r0c0 = r_reg[0];
    assign m_res_r0c1 = r_reg[1];
    assign m_res_r0c2 = r_reg[2];
    assign m_res_r1c0 = r_reg[3];
    assign m_res_r1c1 = r_reg[4];
    assign m_res_r1c2 = r_reg[5];
    assign m_res_r2c0 = r_reg[6];
    assign m_res_r2c1 = r_reg[7];
    assign m_res_r2c2 = r_reg[8];
    assign m_overflow = ovf_reg;
    assign m_div_zero = (mode_reg == OP_DIV) && (scalar_reg == '0);

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready,
        "input taken while busy")
    `ASSERT_IMPL(a_no_write_idle, aclk, aresetn,
        state_reg == ST_IDLE && !clr_reg, !wr_en, "memory written while idle")
    `ASSERT_NEXT(a_out_after_done, aclk, aresetn, state_reg == ST_OUT, m_valid,
        "result not presented after write-back")
    `ASSERT_IMPL(a_div_only_div, aclk, aresetn, drsp.busy, state_reg == ST_DIV,
        "divider active outside divide")

endmodule
